### hw/rtl/wino_pkg.sv
// Shared types, widths, transform matrices and codes for the Winograd tile engine.
package wino_pkg;

  // Widths fixed by the stream format
  localparam int DATA_BITS_DEF = 16;
  localparam int RAW_W         = 24;   // widest sample precision supported
  localparam int SMP_W         = 16;
  localparam int POS_W         = 4;
  localparam int RES_W         = 35;
  localparam int IN_TDATA_W    = 24;
  localparam int OUT_TDATA_W   = 40;

  // Storage and sequencing
  localparam int WGT_N      = 9;
  localparam int TILE_N     = 16;
  localparam int ELEM_N     = 16;    // Winograd-domain elements per tile
  localparam int ELEM_W     = 4;
  localparam int STEP_W     = 5;
  localparam int CALC_STEPS = ELEM_N + 2;  // issue steps plus the transform and product registers

  localparam logic [POS_W-1:0] POS_LAST  = 4'd15;
  localparam logic [POS_W-1:0] WGT_LAST  = 4'd8;
  localparam logic [1:0]       EMIT_LAST = 2'd3;

  typedef enum logic {
    CMD_WEIGHT = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } state_t;

  // Small signed coefficient of a transform matrix
  typedef logic signed [2:0] coef_t;

  localparam coef_t C_ZERO = 3'sd0;
  localparam coef_t C_POS  = 3'sd1;
  localparam coef_t C_NEG  = -3'sd1;
  localparam coef_t C_TWO  = 3'sd2;

  // Input transform Bt
  localparam coef_t MAT_BT [4][4] = '{
    '{C_POS,  C_ZERO, C_NEG, C_ZERO},
    '{C_ZERO, C_POS,  C_POS, C_ZERO},
    '{C_ZERO, C_NEG,  C_POS, C_ZERO},
    '{C_ZERO, C_POS,  C_ZERO, C_NEG}
  };

  // Filter transform 2G, so that U comes out four times larger and integer
  localparam coef_t MAT_G2 [4][3] = '{
    '{C_TWO,  C_ZERO, C_ZERO},
    '{C_POS,  C_POS,  C_POS},
    '{C_POS,  C_NEG,  C_POS},
    '{C_ZERO, C_ZERO, C_TWO}
  };

  // Output transform At
  localparam coef_t MAT_AT [2][4] = '{
    '{C_POS,  C_POS, C_POS,  C_ZERO},
    '{C_ZERO, C_POS, C_NEG,  C_NEG}
  };

  // Store strobes towards the weight and tile registers
  typedef struct packed {
    logic             wgt_we;
    logic             smp_we;
    logic [POS_W-1:0] pos;
  } wr_t;

  // One element issued to the shared transform and multiplier unit
  typedef struct packed {
    logic              vld;
    logic [ELEM_W-1:0] idx;
  } issue_t;

endpackage

### hw/rtl/winograd_f2x2_3x3_tile.sv
// Top level of the Winograd F(2x2,3x3) tile engine.
// Weight loads and tile sample writes are taken one transaction per cycle while the
// engine is idle. A sample write to tile position 15 closes the tile: the engine then
// drops in_tready and runs its shared transform and multiplier unit (one of the 16
// Winograd-domain products per cycle, then the transform and product registers drain),
// and then offers the four results in row-major order, one per cycle while out_tready
// is high, the fourth marked by out_tlast. in_tready returns the cycle after the last
// result is taken. Weights and samples persist between tiles; a weight load to an
// index above 8 is dropped. Results are exact; DATA_BITS sets how many low bits of
// each sample are taken as signed.
module winograd_f2x2_3x3_tile #(
  parameter int DATA_BITS = wino_pkg::DATA_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [wino_pkg::IN_TDATA_W-1:0]     in_tdata,   // position[3:0], sample_value[19:4]
  input  logic                                in_tuser,   // command
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [wino_pkg::OUT_TDATA_W-1:0]    out_tdata,  // out_row[0], out_col[1], conv_result[36:2]
  output logic                                out_tlast
);
  import wino_pkg::*;

  logic [RAW_W-1:0]            raw;
  logic signed [DATA_BITS-1:0] wr_data;
  logic signed [DATA_BITS+3:0] v;
  logic signed [DATA_BITS+3:0] u;
  logic signed [RES_W-1:0]     res;
  wr_t                         wr;
  issue_t                      iss;
  issue_t                      xf_iss;
  logic                        clear;
  logic [1:0]                  sel;

  // Take the low DATA_BITS bits of the sample as two's complement
  assign raw     = {{(RAW_W - SMP_W){1'b0}}, in_tdata[POS_W +: SMP_W]};
  assign wr_data = raw[DATA_BITS-1:0];

  wino_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_cmd     (in_tuser),
    .in_pos     (in_tdata[POS_W-1:0]),
    .out_tready (out_tready),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tlast  (out_tlast),
    .wr         (wr),
    .iss        (iss),
    .clear      (clear),
    .sel        (sel)
  );

  wino_xform #(
    .DATA_BITS (DATA_BITS)
  ) u_xform (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .wr_data (wr_data),
    .iss     (iss),
    .xf_iss  (xf_iss),
    .v_out   (v),
    .u_out   (u)
  );

  wino_mac #(
    .DATA_BITS (DATA_BITS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .clear  (clear),
    .xf_iss (xf_iss),
    .v_in   (v),
    .u_in   (u),
    .sel    (sel),
    .res    (res)
  );

  // Pack row, column and result, row in the lowest bit
  assign out_tdata = {{(OUT_TDATA_W - RES_W - 2){1'b0}}, res, sel[0], sel[1]};

endmodule

### hw/rtl/wino_xform.sv
// Weight and tile storage with the shared transform stage: one V and one U4 element per cycle.
module wino_xform #(
  parameter int DATA_BITS = wino_pkg::DATA_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  wino_pkg::wr_t          wr,
  input  logic signed [DATA_BITS-1:0] wr_data,
  input  wino_pkg::issue_t       iss,
  output wino_pkg::issue_t       xf_iss,
  output logic signed [DATA_BITS+3:0] v_out,
  output logic signed [DATA_BITS+3:0] u_out
);
  import wino_pkg::*;

  localparam int X_W = DATA_BITS + 4;

  logic signed [DATA_BITS-1:0] wgt_r  [WGT_N];
  logic signed [DATA_BITS-1:0] tile_r [TILE_N];
  logic signed [X_W-1:0]       t1     [4];
  logic signed [X_W-1:0]       u1     [3];
  logic signed [X_W-1:0]       v_nxt;
  logic signed [X_W-1:0]       u_nxt;
  logic signed [X_W-1:0]       v_r;
  logic signed [X_W-1:0]       u_r;
  issue_t                      iss_r;
  logic [1:0]                  ri;
  logic [1:0]                  cj;

  // Scale by a transform coefficient: pass, negate, double or drop
  function automatic logic signed [X_W-1:0] cmul(input logic signed [X_W-1:0] x,
                                                 input coef_t k);
    logic signed [X_W-1:0] y;
    case (k)
      C_POS:   y = x;
      C_NEG:   y = -x;
      C_TWO:   y = x <<< 1;
      default: y = '0;
    endcase
    return y;
  endfunction

  // Store weights and tile samples
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < WGT_N; n++) wgt_r[n] <= '0;
      for (int n = 0; n < TILE_N; n++) tile_r[n] <= '0;
    end else begin
      if (wr.wgt_we) wgt_r[wr.pos] <= wr_data;
      if (wr.smp_we) tile_r[wr.pos] <= wr_data;
    end
  end

  // Form one element of V = Bt.d.B and U4 = (2G).g.(2G)t
  always_comb begin
    ri = iss.idx[3:2];
    cj = iss.idx[1:0];
    for (int c = 0; c < 4; c++) begin
      t1[c] = '0;
      for (int l = 0; l < 4; l++) begin
        t1[c] = t1[c] + cmul(X_W'(tile_r[l*4+c]), MAT_BT[ri][l]);
      end
    end
    v_nxt = '0;
    for (int c = 0; c < 4; c++) begin
      v_nxt = v_nxt + cmul(t1[c], MAT_BT[cj][c]);
    end
    for (int c = 0; c < 3; c++) begin
      u1[c] = '0;
      for (int l = 0; l < 3; l++) begin
        u1[c] = u1[c] + cmul(X_W'(wgt_r[l*3+c]), MAT_G2[ri][l]);
      end
    end
    u_nxt = '0;
    for (int c = 0; c < 3; c++) begin
      u_nxt = u_nxt + cmul(u1[c], MAT_G2[cj][c]);
    end
  end

  // Register the transformed pair
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r <= '0;
    end else begin
      iss_r <= iss;
    end
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    u_r <= u_nxt;
  end

  assign xf_iss = iss_r;
  assign v_out  = v_r;
  assign u_out  = u_r;

endmodule

### hw/rtl/wino_mac.sv
// Shared multiplier and the four output accumulators applying At.M.A.
module wino_mac #(
  parameter int DATA_BITS = wino_pkg::DATA_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clear,
  input  wino_pkg::issue_t            xf_iss,
  input  logic signed [DATA_BITS+3:0] v_in,
  input  logic signed [DATA_BITS+3:0] u_in,
  input  logic [1:0]                  sel,
  output logic signed [wino_pkg::RES_W-1:0] res
);
  import wino_pkg::*;

  localparam int X_W   = DATA_BITS + 4;
  localparam int P_W   = 2 * X_W;
  localparam int ACC_W = P_W + 4;

  logic signed [P_W-1:0]   m_r;
  issue_t                  mul_iss_r;
  logic signed [ACC_W-1:0] acc_r   [4];
  logic signed [ACC_W-1:0] acc_nxt [4];
  logic signed [ACC_W-1:0] m_ext;
  logic signed [ACC_W-1:0] acc_sel;
  logic [1:0]              ei;
  logic [1:0]              ej;
  coef_t                   k;

  // Multiply one U4 element by its V element
  always_ff @(posedge clk) begin
    m_r <= v_in * u_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_iss_r <= '0;
    end else begin
      mul_iss_r <= xf_iss;
    end
  end

  // Spread the product onto the four outputs with the At coefficients
  always_comb begin
    ei    = mul_iss_r.idx[3:2];
    ej    = mul_iss_r.idx[1:0];
    m_ext = ACC_W'(m_r);
    k     = C_ZERO;
    for (int r = 0; r < 2; r++) begin
      for (int c = 0; c < 2; c++) begin
        k = coef_t'(MAT_AT[r][ei] * MAT_AT[c][ej]);
        case (k)
          C_POS:   acc_nxt[r*2+c] = acc_r[r*2+c] + m_ext;
          C_NEG:   acc_nxt[r*2+c] = acc_r[r*2+c] - m_ext;
          default: acc_nxt[r*2+c] = acc_r[r*2+c];
        endcase
      end
    end
  end

  // Clear at tile start, accumulate while products arrive
  always_ff @(posedge clk) begin
    if (clear) begin
      for (int n = 0; n < 4; n++) acc_r[n] <= '0;
    end else if (mul_iss_r.vld) begin
      for (int n = 0; n < 4; n++) acc_r[n] <= acc_nxt[n];
    end
  end

  // Divide exactly by four and wrap to the result width
  assign acc_sel = acc_r[sel];

  generate
    if (ACC_W >= RES_W + 2) begin : g_trunc
      assign res = acc_sel[RES_W+1:2];
    end else begin : g_sext
      assign res = {{(RES_W + 2 - ACC_W){acc_sel[ACC_W-1]}}, acc_sel[ACC_W-1:2]};
    end
  endgenerate

endmodule

### hw/rtl/wino_ctrl.sv
// Sequencer: decodes input transactions, steps the shared unit and hands out results.
module wino_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_cmd,
  input  logic [wino_pkg::POS_W-1:0]  in_pos,
  input  logic                        out_tready,
  output logic                        in_tready,
  output logic                        out_tvalid,
  output logic                        out_tlast,
  output wino_pkg::wr_t               wr,
  output wino_pkg::issue_t            iss,
  output logic                        clear,
  output logic [1:0]                  sel
);
  import wino_pkg::*;

  state_t              state_r;
  state_t              state_nxt;
  logic [STEP_W-1:0]   step_r;
  logic [STEP_W-1:0]   step_nxt;
  logic [1:0]          emit_r;
  logic [1:0]          emit_nxt;
  logic                in_acc;
  logic                start;
  logic                out_acc;

  assign in_acc  = in_tvalid && (state_r == ST_IDLE);
  assign start   = in_acc && (in_cmd == CMD_SAMPLE) && (in_pos == POS_LAST);
  assign out_acc = out_tready && (state_r == ST_EMIT);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (start) state_nxt = ST_CALC;
      ST_CALC: if (step_r == STEP_W'(CALC_STEPS - 1)) state_nxt = ST_EMIT;
      ST_EMIT: if (out_acc && (emit_r == EMIT_LAST)) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Advance step and result counters
  always_comb begin
    step_nxt = (state_r == ST_CALC) ? step_r + 1'b1 : '0;
    emit_nxt = emit_r;
    if (state_r != ST_EMIT) begin
      emit_nxt = '0;
    end else if (out_acc) begin
      emit_nxt = emit_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      emit_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      emit_r  <= emit_nxt;
    end
  end

  // Outputs
  always_comb begin
    in_tready  = (state_r == ST_IDLE);
    out_tvalid = (state_r == ST_EMIT);
    out_tlast  = (state_r == ST_EMIT) && (emit_r == EMIT_LAST);
    wr.wgt_we  = in_acc && (in_cmd == CMD_WEIGHT) && (in_pos <= WGT_LAST);
    wr.smp_we  = in_acc && (in_cmd == CMD_SAMPLE);
    wr.pos     = in_pos;
    iss.vld    = (state_r == ST_CALC) && (step_r < STEP_W'(ELEM_N));
    iss.idx    = step_r[ELEM_W-1:0];
    clear      = start;
    sel        = emit_r;
  end

endmodule

### hw/rtl/wino_chk.sv
// Port-level checker for the Winograd tile engine, bound to the top level.
module wino_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [wino_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                             in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [wino_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tlast
);
  import wino_pkg::*;

  // Never take input while results are on offer
  a_idle_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input ready while results pending");

  // Closing a tile stops further input
  a_close_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && (in_tuser == CMD_SAMPLE) &&
     (in_tdata[POS_W-1:0] == POS_LAST)) |=> !in_tready)
    else $error("input still ready after tile close");

  // The last flag marks the bottom-right output only
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[0] && out_tdata[1])))
    else $error("last flag does not match output position");

  // Once the last result is taken, input reopens
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (in_tready && !out_tvalid))
    else $error("engine did not return to idle after last result");

endmodule

bind winograd_f2x2_3x3_tile wino_chk u_chk (.*);

### tb/winograd_f2x2_3x3_tile_tb.sv
// Self-checking testbench for the Winograd F(2x2,3x3) tile engine.
`timescale 1ns / 100ps

module winograd_f2x2_3x3_tile_tb;
  import wino_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 12;
  localparam int IDLE_PCT     = 35;
  localparam int DRAIN_CYCLES = 25;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_END   = 280;
  localparam int ITEMS_END    = 330;

  // One expected result of a closed tile
  typedef struct {
    logic                    row;
    logic                    col;
    logic signed [RES_W-1:0] conv;
    logic                    last;
  } tile_out_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // position[3:0], sample_value[19:4]
  logic                   in_tuser;   // command
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // out_row[0], out_col[1], conv_result[36:2]
  logic                   out_tlast;

  // Predictor copy of the filter and tile stores
  logic signed [SMP_W-1:0] weight_copy [WGT_N];
  logic signed [SMP_W-1:0] sample_copy [TILE_N];
  tile_out_t               pending_outputs [$];

  bit steady;
  int items_sent;
  int tiles_closed;
  int outputs_checked;
  int mismatches;
  int cycle_count;

  winograd_f2x2_3x3_tile dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Update the store copies and, on a tile close, work out the 2x2 correlation
  function automatic void predict_tile_write(cmd_t cmd, logic [POS_W-1:0] pos,
                                             logic signed [SMP_W-1:0] val);
    longint acc;
    tile_out_t res;
    if (cmd == CMD_WEIGHT) begin
      if (pos <= WGT_LAST) weight_copy[pos] = val;
      return;
    end
    sample_copy[pos] = val;
    if (pos != POS_LAST) return;
    tiles_closed++;
    for (int k = 0; k < 4; k++) begin
      acc = 0;
      for (int a = 0; a < 3; a++)
        for (int b = 0; b < 3; b++)
          acc += longint'(sample_copy[((k >> 1) + a) * 4 + (k & 1) + b]) *
                 longint'(weight_copy[a * 3 + b]);
      res.row  = k[1];
      res.col  = k[0];
      res.conv = acc[RES_W-1:0];
      res.last = (k == 3);
      pending_outputs.push_back(res);
    end
  endfunction

  // Offer one transaction, with a random gap first unless steady, and wait for it to be taken
  task automatic send_item(cmd_t cmd, logic [POS_W-1:0] pos, logic signed [SMP_W-1:0] val);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_TDATA_W - SMP_W - POS_W){1'b0}}, val, pos};
    do @(posedge clk); while (!in_tready);
    predict_tile_write(cmd, pos, val);
    items_sent++;
  endtask

  // Sample values biased towards the extremes
  function automatic logic signed [SMP_W-1:0] rand_value();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return '1;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  task automatic send_noise();
    send_item(cmd_t'($urandom_range(1)), POS_W'($urandom_range(15)), rand_value());
  endtask

  // A tile closed straight after reset sees only zero weights
  task automatic test_reset_state();
    send_item(CMD_SAMPLE, POS_LAST, 16'sh7fff);
  endtask

  // Largest magnitude: every weight and sample at the negative extreme
  task automatic test_extreme_tile();
    for (int k = 0; k < WGT_N; k++) send_item(CMD_WEIGHT, POS_W'(k), 16'sh8000);
    for (int p = 0; p < TILE_N; p++) send_item(CMD_SAMPLE, POS_W'(p), 16'sh8000);
  endtask

  // Loads above index 8 are dropped; stale samples stay in the tile
  task automatic test_ignored_weight_index();
    send_item(CMD_WEIGHT, 4'd9, 16'sh7fff);
    send_item(CMD_WEIGHT, 4'd12, 16'sh1234);
    send_item(CMD_WEIGHT, 4'd15, 16'sh7fff);
    send_item(CMD_SAMPLE, POS_LAST, 16'sh7fff);
    send_item(CMD_WEIGHT, 4'd4, 16'sh7fff);
    send_item(CMD_SAMPLE, 4'd5, 16'sh7fff);
    send_item(CMD_SAMPLE, POS_LAST, 16'sh0001);
  endtask

  // Well-formed tiles with random content, partial tiles and stray transactions
  task automatic run_tiles(int stop_at);
    int off;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 40) begin
        off = $urandom_range(WGT_N - 1);
        for (int k = 0; k < WGT_N; k++)
          send_item(CMD_WEIGHT, POS_W'((k + off) % WGT_N), rand_value());
      end
      for (int p = 0; p < TILE_N - 1; p++) begin
        if ($urandom_range(99) < 8) send_noise();
        if ($urandom_range(9) < 7 || $urandom_range(1) == 0)
          send_item(CMD_SAMPLE, POS_W'(p), rand_value());
      end
      send_item(CMD_SAMPLE, POS_LAST, rand_value());
    end
  endtask

  task automatic test_random_tiles();
    run_tiles(RANDOM_END);
  endtask

  // Long stretch with neither side idling
  task automatic test_back_to_back();
    steady = 1'b1;
    run_tiles(ITEMS_END);
    steady = 1'b0;
  endtask

  // Hold the input quiet until every result has arrived, then let the engine settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random output stall, off while steady
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin
    tile_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      outputs_checked++;
      if (pending_outputs.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, tdata %h last %b", $time, out_tdata, out_tlast);
      end else begin
        want = pending_outputs.pop_front();
        if (out_tdata[0] !== want.row) begin
          mismatches++;
          $display("%0t: out_row expected %b actual %b", $time, want.row, out_tdata[0]);
        end
        if (out_tdata[1] !== want.col) begin
          mismatches++;
          $display("%0t: out_col expected %b actual %b", $time, want.col, out_tdata[1]);
        end
        if (out_tdata[RES_W+1:2] !== want.conv) begin
          mismatches++;
          $display("%0t: conv_result expected %0d actual %0d", $time, want.conv,
                   $signed(out_tdata[RES_W+1:2]));
        end
        if (out_tlast !== want.last) begin
          mismatches++;
          $display("%0t: last expected %b actual %b", $time, want.last, out_tlast);
        end
      end
    end
  end

  // Guard against a hung handshake
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("winograd_f2x2_3x3_tile regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= CMD_WEIGHT;
    out_tready <= 1'b0;
    steady      = 1'b0;
    cycle_count = 0;
    items_sent = 0;
    tiles_closed = 0;
    outputs_checked = 0;
    mismatches = 0;
    foreach (weight_copy[k]) weight_copy[k] = '0;
    foreach (sample_copy[k]) sample_copy[k] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_extreme_tile();
    test_ignored_weight_index();
    test_random_tiles();
    test_back_to_back();
    drain();

    $display("Sent %0d transactions closing %0d tiles; checked %0d results, %0d mismatches.",
             items_sent, tiles_closed, outputs_checked, mismatches);
    $display("Covered reset-state tiles, extreme operands, dropped weight loads and stale tiles.");
    if (mismatches == 0 && pending_outputs.size() == 0) begin
      $display("winograd_f2x2_3x3_tile regression: pass");
    end else begin
      $display("winograd_f2x2_3x3_tile regression: fail");
    end
    $finish;
  end

endmodule
